// ===== sv/fptb_pkg.sv =====
package fptb_pkg;

  // default parameter values
  localparam int TIMER_COUNT_DEF = 8;
  localparam int MAX_BLOCK_DEF   = 1024;
  localparam int MAX_FIRES_DEF   = 2;

  // field widths
  localparam int KIND_W  = 2;
  localparam int TID_W   = 3;
  localparam int PER_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 17;
  localparam int CNT_W   = 64;
  localparam int CFG_W   = 11;

  // constants
  localparam int          RESULT_CAP     = 16;
  localparam int          RES_W          = 5;
  localparam int          DEFAULT_BLOCK  = 480;
  localparam logic [PER_W-1:0] DEFAULT_PERIOD = 24'd48000;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_SETP  = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD_WR,
    S_RD,
    S_LOAD,
    S_EVAL,
    S_CMP,
    S_WB,
    S_NEXT,
    S_FIN
  } seq_state_t;

  // one timer entry
  typedef struct packed {
    logic              active;
    logic [CNT_W-1:0]  due;
    logic [PER_W-1:0]  per;
    logic [FRAC_W-1:0] frac;
    logic [ACC_W-1:0]  acc;
  } timer_entry_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic         rd_en;
    logic [TID_W-1:0] rd_addr;
    logic         wr_en;
    logic [TID_W-1:0] wr_addr;
    timer_entry_t wr_data;
  } mem_req_t;

  // entry contents after reset
  function automatic timer_entry_t entry_reset();
    timer_entry_t e;
    e.active = 1'b0;
    e.due    = '0;
    e.per    = DEFAULT_PERIOD;
    e.frac   = '0;
    e.acc    = '0;
    return e;
  endfunction

endpackage

// ===== sv/fptb_cmd_if.sv =====
interface fptb_cmd_if
  import fptb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  tmr_idx;
  logic [PER_W-1:0]  period_whole;
  logic [FRAC_W-1:0] period_fraction;

  modport source(output valid, kind, tmr_idx, period_whole, period_fraction, input ready);
  modport sink(input valid, kind, tmr_idx, period_whole, period_fraction, output ready);
endinterface

// ===== sv/fptb_fire_if.sv =====
interface fptb_fire_if
  import fptb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TID_W-1:0] fired_timer;
  logic             last_fire;

  modport source(output valid, fired_timer, last_fire, input ready);
  modport sink(input valid, fired_timer, last_fire, output ready);
endinterface

// ===== sv/fptb_timer_mem.sv =====
module fptb_timer_mem
  import fptb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  mem_req_t     req,
  output timer_entry_t rd_data
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  timer_entry_t            mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0]  written;
  timer_entry_t            rd_q;
  logic                    rd_written;

  // storage array, synchronous read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr[IW-1:0]];
    end
  end

  // per-entry written flags, an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr[IW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written <= written[req.rd_addr[IW-1:0]];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : entry_reset();

endmodule

// ===== sv/fptb_seq.sv =====
module fptb_seq
  import fptb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int MAX_FIRES   = MAX_FIRES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]    block_size,
  fptb_cmd_if.sink                          cmd,
  fptb_fire_if.source                       fire,
  output mem_req_t                          req,
  input  timer_entry_t                      rd_data
);

  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int FW = $clog2(MAX_FIRES + 1);

  seq_state_t        state, state_next;
  logic [CNT_W-1:0]  sample_count;
  logic [BW-1:0]     block_phase;
  logic [BW-1:0]     phase_inc;
  logic [IW-1:0]     idx;
  logic [FW-1:0]     fires;
  logic [RES_W-1:0]  n_res;
  logic              pend_valid;
  logic [TID_W-1:0]  pend_id;
  timer_entry_t      w;
  logic [CNT_W-1:0]  resched;
  logic              out_valid;
  logic [TID_W-1:0]  out_id;
  logic              out_last;
  kind_t             cmd_kind;
  logic [TID_W-1:0]  cmd_id;
  logic [PER_W-1:0]  cmd_per;
  logic [FRAC_W-1:0] cmd_frac;

  logic              accept;
  logic              id_ok;
  logic              pass_due;
  logic              slot_free;
  logic              go;
  logic              emit;
  logic              push;
  logic              push_last;
  logic [ACC_W-1:0]  acc_sum;
  logic              behind;
  logic              short_per;
  timer_entry_t      cmd_entry;

  assign cmd.ready   = (state == S_IDLE);
  assign accept      = cmd.valid && cmd.ready;
  assign id_ok       = ({1'b0, cmd.tmr_idx} < (TID_W + 1)'(TIMER_COUNT));
  assign phase_inc   = block_phase + BW'(1);
  assign pass_due    = (phase_inc >= block_size);
  assign slot_free   = !out_valid || fire.ready;

  // fire condition and arithmetic for the timer in the working register
  assign go        = (w.due <= sample_count) && (fires < FW'(MAX_FIRES)) &&
                     (n_res < RES_W'(RESULT_CAP));
  assign emit      = (state == S_EVAL) && go && (!pend_valid || slot_free);
  assign acc_sum   = w.acc + {1'b0, w.frac};
  assign behind    = (w.due < sample_count);
  assign short_per = (w.per < {{(PER_W-BW){1'b0}}, block_size});

  // modified entry for start, stop and set period
  always_comb begin
    cmd_entry = rd_data;
    case (cmd_kind)
      KIND_START: begin
        cmd_entry.active = 1'b1;
        cmd_entry.due    = sample_count + {{(CNT_W-PER_W){1'b0}}, rd_data.per};
      end
      KIND_STOP: begin
        cmd_entry.active = 1'b0;
      end
      KIND_SETP: begin
        cmd_entry.per  = cmd_per;
        cmd_entry.frac = cmd_frac;
      end
      default: begin
        cmd_entry = rd_data;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory requests and output pushes
  always_comb begin
    state_next  = state;
    req.rd_en   = 1'b0;
    req.rd_addr = cmd.tmr_idx;
    req.wr_en   = 1'b0;
    req.wr_addr = TID_W'(idx);
    req.wr_data = w;
    push        = 1'b0;
    push_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.kind == KIND_TICK) begin
            if (pass_due) begin
              state_next = S_RD;
            end
          end else if (id_ok) begin
            req.rd_en  = 1'b1;
            state_next = S_CMD_WR;
          end
        end
      end
      S_CMD_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = cmd_id;
        req.wr_data = cmd_entry;
        state_next  = S_IDLE;
      end
      S_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = TID_W'(idx);
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        state_next = rd_data.active ? S_EVAL : S_NEXT;
      end
      S_EVAL: begin
        if (!go) begin
          state_next = S_WB;
        end else if (emit) begin
          push       = pend_valid;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (behind || short_per) begin
          state_next = S_WB;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_WB: begin
        req.wr_en  = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = (idx == IW'(TIMER_COUNT - 1)) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // counters and pass control
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      block_phase  <= '0;
      idx          <= '0;
      fires        <= '0;
      n_res        <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (accept && (cmd.kind == KIND_TICK)) begin
        sample_count <= sample_count + CNT_W'(1);
        block_phase  <= pass_due ? '0 : phase_inc;
        if (pass_due) begin
          idx   <= '0;
          n_res <= '0;
        end
      end
      if (state == S_LOAD) begin
        fires <= '0;
      end
      if (emit) begin
        fires      <= fires + FW'(1);
        n_res      <= n_res + RES_W'(1);
        pend_valid <= 1'b1;
      end else if ((state == S_FIN) && push) begin
        pend_valid <= 1'b0;
      end
      if ((state == S_NEXT) && (idx != IW'(TIMER_COUNT - 1))) begin
        idx <= idx + IW'(1);
      end
    end
  end

  // working copy of the timer under evaluation and latched command
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind <= kind_t'(cmd.kind);
      cmd_id   <= cmd.tmr_idx;
      cmd_per  <= cmd.period_whole;
      cmd_frac <= cmd.period_fraction;
    end
    case (state)
      S_LOAD: begin
        w       <= rd_data;
        resched <= sample_count + {{(CNT_W-PER_W){1'b0}}, rd_data.per};
      end
      S_EVAL: begin
        if (emit) begin
          w.due   <= w.due + {{(CNT_W-PER_W){1'b0}}, w.per} +
                     {{(CNT_W-1){1'b0}}, acc_sum[ACC_W-1]};
          w.acc   <= {1'b0, acc_sum[FRAC_W-1:0]};
          pend_id <= TID_W'(idx);
        end
      end
      S_CMP: begin
        if (behind) begin
          w.due <= resched;
          w.acc <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (fire.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_id   <= pend_id;
      out_last <= push_last;
    end
  end

  assign fire.valid       = out_valid;
  assign fire.fired_timer = out_id;
  assign fire.last_fire   = out_last;

endmodule

// ===== sv/fractional_period_timer_bank_unit.sv =====
// a tick without a pass only advances the counters; start, stop and set period read
// the entry and write it back; a tick with a pass reads every timer in id order and
// writes back the active ones, which stop firing once behind or with a short period
// a held fire output stalls the pass; one item at a time through the timer memory
// reset (synchronous, rst high) clears counters, phase and flags; timers read as
// stopped with period 48000 until first written; block size returns to 480
module fractional_period_timer_bank_unit
  import fptb_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int MAX_FIRES   = MAX_FIRES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  fptb_cmd_if.sink         cmd,
  fptb_fire_if.source      fire,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int BW        = $clog2(MAX_BLOCK + 1);
  localparam int RST_BLOCK = (DEFAULT_BLOCK > MAX_BLOCK) ? MAX_BLOCK : DEFAULT_BLOCK;

  logic [BW-1:0] block_size;
  logic [BW-1:0] block_size_next;
  mem_req_t      req;
  timer_entry_t  rd_data;

  // clamp written block size to 1..MAX_BLOCK
  always_comb begin
    if (cfg_data == '0) begin
      block_size_next = BW'(1);
    end else if (32'(cfg_data) > 32'(MAX_BLOCK)) begin
      block_size_next = BW'(MAX_BLOCK);
    end else begin
      block_size_next = BW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BW'(RST_BLOCK);
    end else if (cfg_we) begin
      block_size <= block_size_next;
    end
  end

  fptb_timer_mem #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rd_data(rd_data)
  );

  fptb_seq #(
    .TIMER_COUNT(TIMER_COUNT),
    .MAX_BLOCK  (MAX_BLOCK),
    .MAX_FIRES  (MAX_FIRES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .block_size(block_size),
    .cmd       (cmd),
    .fire      (fire),
    .req       (req),
    .rd_data   (rd_data)
  );

endmodule

// ===== tb/sv/fractional_period_timer_bank_unit_tb.sv =====
module fractional_period_timer_bank_unit_tb;
  import fptb_pkg::*;

  localparam int NT         = TIMER_COUNT_DEF;
  localparam int FIRES_MAX  = MAX_FIRES_DEF;
  localparam int CYCLE_CAP  = 500000;
  localparam int DRAIN_WAIT = 100;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_PCT   = 15;
  localparam int RAND_ITEMS = 240;
  localparam int PHASE_LEN  = 40;
  localparam logic [ACC_W-1:0] ONE_SAMPLE = 17'h10000;

  typedef struct {
    kind_t             kind;
    logic [TID_W-1:0]  tid;
    logic [PER_W-1:0]  whole;
    logic [FRAC_W-1:0] frac;
  } cmd_item_t;

  typedef struct {
    logic [TID_W-1:0] tid;
    logic             last;
  } fire_rec_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  fptb_cmd_if  cmd_ch ();
  fptb_fire_if fire_ch ();

  fractional_period_timer_bank_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .fire     (fire_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // timer bank shadow state
  logic [CFG_W-1:0]  blk_size;
  logic [CNT_W-1:0]  samples;
  logic [CFG_W-1:0]  blk_phase;
  logic              t_active [NT];
  logic [CNT_W-1:0]  t_due    [NT];
  logic [PER_W-1:0]  t_per    [NT];
  logic [FRAC_W-1:0] t_frac   [NT];
  logic [ACC_W-1:0]  t_acc    [NT];

  cmd_item_t pending_cmds [$];
  fire_rec_t due_fires [$];
  cmd_item_t offered;

  int errors;
  int cycles;
  int hold_left;
  bit hold_req;
  bit hold_done;
  bit quiet;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic [CFG_W-1:0] clamp_block(input logic [CFG_W-1:0] v);
    if (v == 0) return CFG_W'(1);
    if (v > MAX_BLOCK_DEF) return CFG_W'(MAX_BLOCK_DEF);
    return v;
  endfunction

  // shadow bank back to its reset contents
  function automatic void reset_shadow();
    samples = '0;
    blk_phase = '0;
    for (int i = 0; i < NT; i++) begin
      t_active[i] = 1'b0;
      t_due[i] = '0;
      t_per[i] = DEFAULT_PERIOD;
      t_frac[i] = '0;
      t_acc[i] = '0;
    end
  endfunction

  // one evaluation pass over all timers in id order
  function automatic void eval_timers();
    fire_rec_t batch [$];
    fire_rec_t rec;
    int fires;
    for (int i = 0; i < NT; i++) begin
      fires = 0;
      if (!t_active[i]) continue;
      while (t_due[i] <= samples && fires < FIRES_MAX && batch.size() < RESULT_CAP) begin
        rec.tid = TID_W'(i);
        rec.last = 1'b0;
        batch.push_back(rec);
        fires++;
        t_due[i] = t_due[i] + t_per[i];
        t_acc[i] = t_acc[i] + t_frac[i];
        // fractional remainder carries into one extra sample
        if (t_acc[i] >= ONE_SAMPLE) begin
          t_due[i] = t_due[i] + 1;
          t_acc[i] = t_acc[i] - ONE_SAMPLE;
        end
        // still behind: jump ahead and drop the remainder
        if (t_due[i] < samples) begin
          t_due[i] = samples + t_per[i];
          t_acc[i] = '0;
          break;
        end
        if (t_per[i] < blk_size) break;
      end
    end
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) due_fires.push_back(batch[k]);
  endfunction

  // advance the shadow bank by one accepted item
  function automatic void step_timer_bank(input cmd_item_t it);
    case (it.kind)
      KIND_TICK: begin
        samples = samples + 1;
        blk_phase = blk_phase + 1;
        if (blk_phase >= blk_size) begin
          blk_phase = '0;
          eval_timers();
        end
      end
      KIND_START: begin
        t_active[it.tid] = 1'b1;
        t_due[it.tid] = samples + t_per[it.tid];
      end
      KIND_STOP: t_active[it.tid] = 1'b0;
      default: begin
        t_per[it.tid] = it.whole;
        t_frac[it.tid] = it.frac;
      end
    endcase
  endfunction

  function automatic cmd_item_t make_cmd(input kind_t k, input int tid, input int whole,
                                         input int frac);
    cmd_item_t it;
    it.kind = k;
    it.tid = TID_W'(tid);
    it.whole = PER_W'(whole);
    it.frac = FRAC_W'(frac);
    return it;
  endfunction

  // random item: mostly ticks, short periods so passes actually fire
  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) it.kind = KIND_TICK;
    else if (r < 74) it.kind = KIND_START;
    else if (r < 80) it.kind = KIND_STOP;
    else it.kind = KIND_SETP;
    it.tid = TID_W'($urandom_range(0, NT - 1));
    r = $urandom_range(0, 99);
    if (r < 70) it.whole = PER_W'($urandom_range(0, 40));
    else if (r < 90) it.whole = PER_W'($urandom_range(0, 3000));
    else it.whole = PER_W'($urandom);
    if ($urandom_range(0, 99) < 20) it.frac = '0;
    else it.frac = FRAC_W'($urandom);
    return it;
  endfunction

  task automatic write_block_size(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    blk_size = clamp_block(v);
  endtask

  // wait until every item is taken and every fire has come back
  task automatic settle();
    @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || due_fires.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.kind <= KIND_TICK;
      cmd_ch.tmr_idx <= '0;
      cmd_ch.period_whole <= '0;
      cmd_ch.period_fraction <= '0;
      reset_shadow();
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) step_timer_bank(offered);
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = pending_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.kind <= offered.kind;
          cmd_ch.tmr_idx <= offered.tid;
          cmd_ch.period_whole <= offered.whole;
          cmd_ch.period_fraction <= offered.frac;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while commands keep coming
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_done && fire_ch.valid) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // fire monitor and receiver back-pressure
  always @(posedge clk) begin
    fire_rec_t want;
    if (rst) begin
      fire_ch.ready <= 1'b0;
    end else begin
      if (fire_ch.valid && fire_ch.ready) begin
        if (due_fires.size() == 0) begin
          report_mismatch($sformatf("unexpected fire timer=%0d last=%0b",
                                    fire_ch.fired_timer, fire_ch.last_fire));
        end else begin
          want = due_fires.pop_front();
          if (fire_ch.fired_timer !== want.tid)
            report_mismatch($sformatf("fired_timer %0d, want %0d",
                                      fire_ch.fired_timer, want.tid));
          if (fire_ch.last_fire !== want.last)
            report_mismatch($sformatf("last_fire %0b, want %0b (timer %0d)",
                                      fire_ch.last_fire, want.last, want.tid));
        end
      end
      if (hold_left != 0) begin
        fire_ch.ready <= 1'b0;
      end else begin
        fire_ch.ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // stimulus sequence
  initial begin
    int phase;
    int sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    quiet = 1'b0;
    blk_size = CFG_W'(DEFAULT_BLOCK);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: block size 1 so every tick runs a pass
    write_block_size('0);
    hold_req = 1'b1;
    @(negedge clk);
    pending_cmds.push_back(make_cmd(KIND_SETP, 0, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_SETP, 7, 24'hFFFFFF, 0));
    pending_cmds.push_back(make_cmd(KIND_SETP, 1, 3, 16'h8000));
    pending_cmds.push_back(make_cmd(KIND_START, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_START, 1, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_START, 7, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_START, 2, 0, 0));
    repeat (6) pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_STOP, 1, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0));
    // new period leaves the old schedule alone until restarted
    pending_cmds.push_back(make_cmd(KIND_SETP, 2, 1, 1));
    pending_cmds.push_back(make_cmd(KIND_START, 2, 0, 0));
    repeat (2) pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_STOP, 0, 0, 0));
    pending_cmds.push_back(make_cmd(KIND_SETP, 3, 2, 0));
    pending_cmds.push_back(make_cmd(KIND_START, 3, 0, 0));
    repeat (3) pending_cmds.push_back(make_cmd(KIND_TICK, 0, 0, 0));
    settle();

    // random phases over a range of block sizes
    phase = 0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case (phase % 6)
        0: write_block_size(11'h7FF);
        1: write_block_size(11'd1);
        2: write_block_size(CFG_W'($urandom_range(2, 16)));
        3: write_block_size(CFG_W'(MAX_BLOCK_DEF));
        4: write_block_size(CFG_W'($urandom_range(1, 6)));
        default: write_block_size(CFG_W'($urandom_range(0, 2047)));
      endcase
      quiet = (phase == 2);
      @(negedge clk);
      repeat (PHASE_LEN) pending_cmds.push_back(random_cmd());
      sent += PHASE_LEN;
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
